/* rtl/fcfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fcfa_pkg;

    // Fixed field widths.
    localparam int ENTRY_W   = 28;
    localparam int BYTES_W   = 24;
    localparam int IDX_W     = 10;
    localparam int ADDR_W    = 10;
    localparam int QUO_W     = BYTES_W + 1;
    localparam int CFG_IDX_W = 1;

    // Map entry codes.
    localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'hFFFFFFF;
    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY  = 28'h0000000;
    localparam logic [ENTRY_W-1:0] RSV_ZERO_RST = 28'hFFFFFF8;
    localparam logic [ENTRY_W-1:0] RSV_ONE_RST  = 28'hFFFFFFF;

    // First cluster that allocation may hand out.
    localparam int FIRST_FREE = 3;

    // Map entries with a fixed role on format.
    localparam int RSV_ZERO_IDX = 0;
    localparam int RSV_ONE_IDX  = 1;
    localparam int ROOT_IDX     = 2;

    typedef enum logic [1:0] {
        ACT_FILE   = 2'd0,
        ACT_FOLDER = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_FORMAT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RSV_ZERO = 1'b0,
        REG_RSV_ONE  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_FORMAT,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_LINK,
        S_LOOK,
        S_LOOK_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        action_t              action;
        logic [BYTES_W-1:0]   byte_count;
        logic [IDX_W-1:0]     cluster_index;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     start_cluster;
        logic [ENTRY_W-1:0]   entry_value;
    } out_word_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [ENTRY_W-1:0]   wr_data;
    } map_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUO_W-1:0]     quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/fcfa_map_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcfa_map_mem
    import fcfa_pkg::*;
#(
    parameter int DEPTH = 512
)
(
    input  wire logic                 clk,
    input  wire map_req_t             req,
    output logic [ENTRY_W-1:0]        rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/fcfa_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcfa_div
    import fcfa_pkg::*;
#(
    parameter int DIVISOR = 2048
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [QUO_W-1:0]     dividend,
    output div_rsp_t                  rsp
);

    // Division by the constant cluster size as a multiply by the rounded-up
    // reciprocal. The shift covers the dividend width plus the base-2 log of
    // the divisor rounded up, so the truncated product is the exact quotient.
    localparam int LW = $clog2(DIVISOR);
    localparam int MW = QUO_W + 1;
    localparam int PW = QUO_W + MW;
    localparam int SH = QUO_W + LW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

    logic                done_reg;
    logic [PW-1:0]       prod_reg;

    // The quotient is ready in the cycle after start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Product of the dividend and the reciprocal.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(dividend) * PW'(RECIP_C);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = QUO_W'(prod_reg[PW-1:SH]);

endmodule

`default_nettype wire

/* rtl/fcfa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcfa_ctrl
    import fcfa_pkg::*;
#(
    parameter int MAP_ENTRIES   = 512,
    parameter int CLUSTER_BYTES = 2048
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_word_t             in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_word_t                 out_word,
    input  wire logic [ENTRY_W-1:0]   rsv_zero,
    input  wire logic [ENTRY_W-1:0]   rsv_one,
    output map_req_t                  map_req,
    input  wire logic [ENTRY_W-1:0]   map_rd_data,
    output logic                      div_start,
    output logic [QUO_W-1:0]          div_dividend,
    input  wire div_rsp_t             div_rsp
);

    localparam int AW = $clog2(MAP_ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FIRST_IDX = CW'(FIRST_FREE);
    localparam logic [CW-1:0] LAST_IDX  = CW'(MAP_ENTRIES - 1);
    localparam logic [CW-1:0] END_IDX   = CW'(MAP_ENTRIES);
    localparam logic [CW-1:0] ZERO_IDX  = CW'(RSV_ZERO_IDX);
    localparam logic [CW-1:0] ONE_IDX   = CW'(RSV_ONE_IDX);
    localparam logic [CW-1:0] ROOT_I    = CW'(ROOT_IDX);
    localparam logic [IDX_W:0] MAP_LIMIT = (IDX_W + 1)'(MAP_ENTRIES);
    localparam logic [QUO_W-1:0] ROUND_UP = QUO_W'(CLUSTER_BYTES - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      run_reg;
    logic [AW-1:0]      start_reg;
    logic [AW-1:0]      end_reg;
    logic [QUO_W-1:0]   need_reg;
    logic               rd_valid_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               boot_reg;
    out_word_t          res_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic               accept;
    action_t            eff_action;
    logic               out_of_range;
    logic               slot_free;
    logic               scan_issue;
    logic               entry_empty;
    logic [CW-1:0]      run_inc;
    logic               scan_hit;
    logic               scan_fail;
    logic [AW-1:0]      link_first;
    logic               link_last;
    logic [ENTRY_W-1:0] fmt_data;

    // Request decode and scan bookkeeping.
    always_comb
    begin
        accept       = in_valid && (state_reg == S_IDLE);
        eff_action   = in_word.action;
        if ((in_word.action == ACT_FILE) && (in_word.byte_count == '0))
        begin
            eff_action = ACT_FOLDER;
        end
        out_of_range = ({1'b0, in_word.cluster_index} >= MAP_LIMIT);
        slot_free    = !out_valid_reg || out_ready;
        scan_issue   = (ptr_reg != END_IDX);
        entry_empty  = (map_rd_data == EMPTY_ENTRY);
        run_inc      = run_reg + CW'(1);
        scan_hit     = rd_valid_reg && entry_empty && (QUO_W'(run_inc) >= need_reg);
        scan_fail    = !rd_valid_reg && !scan_issue;
        link_first   = (run_reg == '0) ? rd_addr_reg : start_reg;
        link_last    = (ptr_reg[AW-1:0] == end_reg);
    end

    // Value that format places in the entry under the pointer.
    always_comb
    begin
        priority if (ptr_reg == ZERO_IDX)
        begin
            fmt_data = boot_reg ? RSV_ZERO_RST : rsv_zero;
        end
        else if (ptr_reg == ONE_IDX)
        begin
            fmt_data = boot_reg ? RSV_ONE_RST : rsv_one;
        end
        else if (ptr_reg == ROOT_I)
        begin
            fmt_data = END_OF_CHAIN;
        end
        else
        begin
            fmt_data = EMPTY_ENTRY;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_FORMAT:
            begin
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (eff_action)
                        ACT_FILE:   state_next = S_DIV;
                        ACT_FOLDER: state_next = S_SCAN;
                        ACT_LOOKUP: state_next = out_of_range ? S_DONE : S_LOOK;
                        ACT_FORMAT: state_next = S_FORMAT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_LINK;
                end
                else if (scan_fail)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                if (link_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_LOOK:      state_next = S_LOOK_WAIT;
            S_LOOK_WAIT: state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory requests, divider start and handshake outputs.
    always_comb
    begin
        map_req         = '0;
        map_req.rd_addr = ADDR_W'(ptr_reg[AW-1:0]);
        map_req.wr_addr = ADDR_W'(ptr_reg[AW-1:0]);
        unique case (state_reg)
            S_FORMAT:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_data = fmt_data;
            end
            S_SCAN:
            begin
                map_req.rd_en = scan_issue;
            end
            S_LINK:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_data = link_last ? END_OF_CHAIN
                                            : ENTRY_W'(ptr_reg + CW'(1));
            end
            S_LOOK:
            begin
                map_req.rd_en = 1'b1;
            end
            default:
            begin
                map_req.rd_en = 1'b0;
            end
        endcase
        in_ready     = (state_reg == S_IDLE);
        div_start    = accept && (eff_action == ACT_FILE);
        div_dividend = QUO_W'(in_word.byte_count) + ROUND_UP;
        out_valid    = out_valid_reg;
        out_word     = out_word_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FORMAT;
            ptr_reg       <= '0;
            boot_reg      <= 1'b1;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_SCAN) && scan_issue && !scan_hit;

            // Pointer used by the sweep, the scan, the link pass and lookup.
            unique case (state_reg)
                S_FORMAT:
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    if (ptr_reg == LAST_IDX)
                    begin
                        boot_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (eff_action)
                            ACT_LOOKUP: ptr_reg <= CW'(in_word.cluster_index[AW-1:0]);
                            ACT_FORMAT: ptr_reg <= '0;
                            default:    ptr_reg <= FIRST_IDX;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        ptr_reg <= CW'(link_first);
                    end
                    else if (scan_issue)
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                S_LINK:
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase

            // Output register: loaded once the result is complete.
            if ((state_reg == S_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan and result datapath.
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= ptr_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                res_reg <= '{status: (accept && (eff_action == ACT_LOOKUP) && out_of_range)
                                     ? ST_RANGE : ST_OK,
                             start_cluster: '0,
                             entry_value: '0};
                run_reg <= '0;
                need_reg <= QUO_W'(1);
            end
            S_DIV:
            begin
                need_reg <= div_rsp.quotient;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    start_reg <= link_first;
                    end_reg   <= rd_addr_reg;
                end
                else if (rd_valid_reg)
                begin
                    if (entry_empty)
                    begin
                        run_reg <= run_inc;
                        if (run_reg == '0)
                        begin
                            start_reg <= rd_addr_reg;
                        end
                    end
                    else
                    begin
                        run_reg <= '0;
                    end
                end
                else if (scan_fail)
                begin
                    res_reg.status <= ST_NO_SPACE;
                end
            end
            S_LINK:
            begin
                if (link_last)
                begin
                    res_reg.start_cluster <= IDX_W'(start_reg);
                end
            end
            S_LOOK_WAIT:
            begin
                res_reg.entry_value <= map_rd_data;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_word_reg <= res_reg;
                end
            end
            default:
            begin
                run_reg <= run_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/fat_cluster_first_fit_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// FAT cluster map allocator. The map of MAP_ENTRIES 28-bit entries lives in one
// single-port-read, single-port-write memory, and every format or allocation
// walks it one entry per cycle, so one word is handled at a time. After reset
// the block runs a format sweep over every map entry before in_ready rises;
// configuration writes are taken during that sweep but apply from the next
// format request. Per word: a lookup reads one entry; a format writes every
// entry; a folder allocation scans the map first-fit from FIRST_FREE through
// the memory read port and then writes the found entry; a file allocation
// first turns the byte count into clusters in the divider, then scans for a
// run that long and links each cluster of the run. A finished word waits in
// the output register while the next request is taken and worked on.
module fat_cluster_first_fit_allocator_top
    import fcfa_pkg::*;
#(
    parameter int MAP_ENTRIES   = 512,
    parameter int CLUSTER_BYTES = 2048
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_word_t               in_word,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_word_t                   out_word,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ENTRY_W-1:0]     cfg_data
);

    logic [ENTRY_W-1:0] rsv_zero_reg;
    logic [ENTRY_W-1:0] rsv_one_reg;
    map_req_t           map_req;
    logic [ENTRY_W-1:0] map_rd_data;
    logic               div_start;
    logic [QUO_W-1:0]   div_dividend;
    div_rsp_t           div_rsp;

    // Reserved entry values, used at the next format.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_zero_reg <= RSV_ZERO_RST;
            rsv_one_reg  <= RSV_ONE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RSV_ZERO: rsv_zero_reg <= cfg_data;
                REG_RSV_ONE:  rsv_one_reg  <= cfg_data;
                default:      rsv_zero_reg <= rsv_zero_reg;
            endcase
        end
    end

    fcfa_map_mem #(
        .DEPTH (MAP_ENTRIES)
    ) u_map_mem (
        .clk     (clk),
        .req     (map_req),
        .rd_data (map_rd_data)
    );

    fcfa_div #(
        .DIVISOR (CLUSTER_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .rsp      (div_rsp)
    );

    fcfa_ctrl #(
        .MAP_ENTRIES   (MAP_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word),
        .rsv_zero     (rsv_zero_reg),
        .rsv_one      (rsv_one_reg),
        .map_req      (map_req),
        .map_rd_data  (map_rd_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_rsp      (div_rsp)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fcfa_pkg::*;

    localparam int MAP_ENTRIES   = 512;
    localparam int CLUSTER_BYTES = 2048;
    localparam int HOLD_CYCLES   = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;
    logic cfg_write = 1'b0;
    cfg_reg_t cfg_index = REG_RSV_ZERO;
    logic [ENTRY_W-1:0] cfg_data = '0;

    // Shadow of the cluster map and of the two reserved-entry registers.
    logic [ENTRY_W-1:0] fat_shadow [MAP_ENTRIES];
    logic [ENTRY_W-1:0] rsv_zero_shadow = RSV_ZERO_RST;
    logic [ENTRY_W-1:0] rsv_one_shadow  = RSV_ONE_RST;

    out_word_t pending_results [$];
    int mismatch_count = 0;
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    fat_cluster_first_fit_allocator_top #(
        .MAP_ENTRIES   (MAP_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #25ms;
        $display("TB_ERROR");
        $finish;
    end

    // A format puts the reserved values in entries 0 and 1, closes the root
    // chain in entry 2 and empties everything above.
    function automatic void format_shadow();
        fat_shadow[RSV_ZERO_IDX] = rsv_zero_shadow;
        fat_shadow[RSV_ONE_IDX]  = rsv_one_shadow;
        fat_shadow[ROOT_IDX]     = END_OF_CHAIN;
        for (int i = FIRST_FREE; i < MAP_ENTRIES; i++)
            fat_shadow[i] = EMPTY_ENTRY;
    endfunction

    // First-fit search for a run of empty clusters; 0 means no run was found.
    function automatic int first_fit_run(input int needed);
        int run;
        int start;
        run = 0;
        start = 0;
        if (needed == 0 || needed > MAP_ENTRIES)
            return 0;
        for (int i = FIRST_FREE; i < MAP_ENTRIES; i++)
        begin
            if (fat_shadow[i] == EMPTY_ENTRY)
            begin
                if (run == 0)
                    start = i;
                run++;
                if (run >= needed)
                    return start;
            end
            else
                run = 0;
        end
        return 0;
    endfunction

    // Applies one request to the shadow map and returns the word it produces.
    function automatic out_word_t allocate_and_predict(input in_word_t req);
        out_word_t res;
        action_t act;
        int needed;
        int start;
        res.status = ST_OK;
        res.start_cluster = '0;
        res.entry_value = '0;
        act = req.action;
        // A file of zero bytes is served as a folder.
        if (act == ACT_FILE && req.byte_count == '0)
            act = ACT_FOLDER;
        case (act)
            ACT_FILE:
            begin
                needed = (int'(req.byte_count) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
                start = first_fit_run(needed);
                if (start == 0)
                    res.status = ST_NO_SPACE;
                else
                begin
                    for (int k = start; k < start + needed - 1; k++)
                        fat_shadow[k] = ENTRY_W'(k + 1);
                    fat_shadow[start + needed - 1] = END_OF_CHAIN;
                    res.start_cluster = IDX_W'(start);
                end
            end
            ACT_FOLDER:
            begin
                start = first_fit_run(1);
                if (start == 0)
                    res.status = ST_NO_SPACE;
                else
                begin
                    fat_shadow[start] = END_OF_CHAIN;
                    res.start_cluster = IDX_W'(start);
                end
            end
            ACT_LOOKUP:
            begin
                if (int'(req.cluster_index) >= MAP_ENTRIES)
                    res.status = ST_RANGE;
                else
                    res.entry_value = fat_shadow[int'(req.cluster_index)];
            end
            default:
                format_shadow();
        endcase
        return res;
    endfunction

    function automatic in_word_t make_request(input action_t act, input int bytes,
                                              input int index);
        in_word_t req;
        req.action = act;
        req.byte_count = BYTES_W'(bytes);
        req.cluster_index = IDX_W'(index);
        return req;
    endfunction

    // Offers one word, with an optional idle burst first, and records its
    // expected result once it is accepted.
    task automatic send_request(input in_word_t req);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(allocate_and_predict(req));
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register writes are only issued while the block is idle.
    task automatic write_register(input cfg_reg_t idx, input logic [ENTRY_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_RSV_ZERO)
            rsv_zero_shadow = value;
        else
            rsv_one_shadow = value;
        @(posedge clk);
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing expected: expected none, got %h", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
        begin
            $display("%0t: status: expected %0d, got %0d", $time, want.status, got.status);
            mismatch_count++;
        end
        if (got.start_cluster !== want.start_cluster)
        begin
            $display("%0t: start_cluster: expected %0d, got %0d", $time,
                     want.start_cluster, got.start_cluster);
            mismatch_count++;
        end
        if (got.entry_value !== want.entry_value)
        begin
            $display("%0t: entry_value: expected %h, got %h", $time,
                     want.entry_value, got.entry_value);
            mismatch_count++;
        end
    endtask

    // Result side: checks each accepted word and drives ready, with short
    // random stalls and, on request, one long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result(out_word);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Reserved entries, range limits and simple chains on the reset map.
    task automatic test_reset_map_and_limits();
        send_request(make_request(ACT_LOOKUP, 0, 0));
        send_request(make_request(ACT_LOOKUP, 0, 1));
        send_request(make_request(ACT_LOOKUP, 0, 2));
        send_request(make_request(ACT_LOOKUP, 0, 3));
        send_request(make_request(ACT_LOOKUP, 0, MAP_ENTRIES - 1));
        send_request(make_request(ACT_LOOKUP, 0, MAP_ENTRIES));
        send_request(make_request(ACT_LOOKUP, 0, 1023));
        // One byte, exactly one cluster, and one byte over a cluster.
        send_request(make_request(ACT_FILE, 1, 0));
        send_request(make_request(ACT_FILE, CLUSTER_BYTES, 0));
        send_request(make_request(ACT_FILE, CLUSTER_BYTES + 1, 1023));
        send_request(make_request(ACT_LOOKUP, 0, 5));
        send_request(make_request(ACT_LOOKUP, 0, 6));
        // Zero-byte file behaves as a folder.
        send_request(make_request(ACT_FILE, 0, 0));
        send_request(make_request(ACT_FOLDER, 16777215, 1023));
        // Larger than the whole map.
        send_request(make_request(ACT_FILE, 16777215, 0));
        send_request(make_request(ACT_FILE, (MAP_ENTRIES + 1) * CLUSTER_BYTES, 0));
        wait_drained();
    endtask

    // Fill the map with one file, then show that nothing more fits.
    task automatic test_full_map();
        send_request(make_request(ACT_FORMAT, 0, 0));
        send_request(make_request(ACT_FILE, (MAP_ENTRIES - FIRST_FREE) * CLUSTER_BYTES, 0));
        send_request(make_request(ACT_FOLDER, 0, 0));
        send_request(make_request(ACT_FILE, 0, 0));
        send_request(make_request(ACT_FILE, 1, 0));
        send_request(make_request(ACT_LOOKUP, 0, MAP_ENTRIES - 2));
        send_request(make_request(ACT_LOOKUP, 0, MAP_ENTRIES - 1));
        // One cluster more than the free area, though not more than the map.
        send_request(make_request(ACT_FORMAT, 0, 0));
        send_request(make_request(ACT_FILE, (MAP_ENTRIES - FIRST_FREE + 1) * CLUSTER_BYTES, 0));
        send_request(make_request(ACT_LOOKUP, 0, FIRST_FREE));
        wait_drained();
    endtask

    // Reserved values take effect only at the next format.
    task automatic test_reserved_registers();
        logic [ENTRY_W-1:0] values [3];
        values[0] = '0;
        values[1] = '1;
        values[2] = ENTRY_W'($urandom());
        for (int n = 0; n < 3; n++)
        begin
            write_register(REG_RSV_ZERO, values[n]);
            write_register(REG_RSV_ONE, ~values[(n + 2) % 3]);
            send_request(make_request(ACT_LOOKUP, 0, RSV_ZERO_IDX));
            send_request(make_request(ACT_FORMAT, 0, 0));
            send_request(make_request(ACT_LOOKUP, 0, RSV_ZERO_IDX));
            send_request(make_request(ACT_LOOKUP, 0, RSV_ONE_IDX));
            wait_drained();
        end
    endtask

    // Mostly allocations and lookups near the low end of the map, where the
    // chains land, with some full-range fields and an occasional format.
    task automatic test_random_traffic(input int count);
        in_word_t req;
        int pick;
        int size_pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            size_pick = $urandom_range(0, 99);
            req.byte_count = BYTES_W'($urandom());
            req.cluster_index = IDX_W'($urandom());
            if (pick < 35)
            begin
                req.action = ACT_FILE;
                if (size_pick < 60)
                    req.byte_count = BYTES_W'($urandom_range(1, 8 * CLUSTER_BYTES));
                else if (size_pick < 85)
                    req.byte_count = BYTES_W'($urandom_range(1, 64 * CLUSTER_BYTES));
                else if (size_pick < 95)
                    req.byte_count = BYTES_W'($urandom());
                else
                    req.byte_count = '0;
            end
            else if (pick < 50)
                req.action = ACT_FOLDER;
            else if (pick < 97)
            begin
                req.action = ACT_LOOKUP;
                if (size_pick < 75)
                    req.cluster_index = IDX_W'($urandom_range(0, 127));
            end
            else
                req.action = ACT_FORMAT;
            send_request(req);
        end
        wait_drained();
    endtask

    // The result side holds off while lookups keep coming, so the block
    // fills up and stops taking words.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 8; n++)
            send_request(make_request(ACT_LOOKUP, 0, $urandom_range(0, 1023)));
        wait_drained();
    endtask

    initial
    begin
        format_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_map_and_limits();
        test_full_map();
        test_reserved_registers();
        test_random_traffic(240);
        write_register(REG_RSV_ZERO, ENTRY_W'($urandom()));
        write_register(REG_RSV_ONE, ENTRY_W'($urandom()));
        test_random_traffic(200);
        test_output_backpressure();
        // Final stretch runs with no input gaps and the result side always ready.
        idle_on = 1'b0;
        test_random_traffic(70);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/fcfa_pkg.sv
rtl/fcfa_map_mem.sv
rtl/fcfa_div.sv
rtl/fcfa_ctrl.sv
rtl/fat_cluster_first_fit_allocator_top.sv
dv/tb.sv
